>>> src/dwcs_pkg.sv
// types, constants and address helpers for the display window command sequencer
// no dependencies; used by the front end, queue, sequencer, top level and testbench
package dwcs_pkg;

  localparam int WORD_W      = 16;
  localparam int CMD_W       = 8;
  localparam int ROT_W       = 3;
  localparam int SIZE_W      = 11;
  localparam int OFFSET_W    = 10;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 11;

  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  // controller command codes
  localparam logic [CMD_W-1:0] CMD_H_START  = 8'h37;
  localparam logic [CMD_W-1:0] CMD_H_END    = 8'h36;
  localparam logic [CMD_W-1:0] CMD_H_CURSOR = 8'h20;
  localparam logic [CMD_W-1:0] CMD_V_START  = 8'h39;
  localparam logic [CMD_W-1:0] CMD_V_END    = 8'h38;
  localparam logic [CMD_W-1:0] CMD_V_CURSOR = 8'h21;

  // one bit per rotation code: set when that axis is mirrored
  localparam logic [7:0] MIRROR_H_SET = 8'b1100_0110;
  localparam logic [7:0] MIRROR_V_SET = 8'b1001_1100;

  localparam logic [ROT_W-1:0]    ROTATION_RESET      = 3'd0;
  localparam logic [SIZE_W-1:0]   H_SIZE_RESET        = 11'd176;
  localparam logic [SIZE_W-1:0]   V_SIZE_RESET        = 11'd220;
  localparam logic [OFFSET_W-1:0] OFFSET_RESET        = 10'd0;
  localparam logic [CMD_W-1:0]    FINAL_COMMAND_RESET = 8'h22;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_ROTATION      = 3'd0,
    REG_H_SIZE        = 3'd1,
    REG_V_SIZE        = 3'd2,
    REG_COLUMN_OFFSET = 3'd3,
    REG_ROW_OFFSET    = 3'd4,
    REG_FINAL_COMMAND = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [ROT_W-1:0]    rotation_code;
    logic [SIZE_W-1:0]   h_size;
    logic [SIZE_W-1:0]   v_size;
    logic [OFFSET_W-1:0] column_offset;
    logic [OFFSET_W-1:0] row_offset;
  } geom_cfg_t;

  // address words of one axis, already offset and byte swapped
  typedef struct packed {
    logic [WORD_W-1:0] start_word;
    logic [WORD_W-1:0] end_word;
    logic [WORD_W-1:0] cursor_word;
  } axis_words_t;

  typedef struct packed {
    logic        send_h;
    logic        send_v;
    axis_words_t h;
    axis_words_t v;
  } win_entry_t;

  typedef struct packed {
    logic       valid;
    win_entry_t entry;
  } push_t;

  typedef enum logic [3:0] {
    SEQ_NEXT,
    SEQ_H_START_CMD,
    SEQ_H_START_DAT,
    SEQ_H_END_CMD,
    SEQ_H_END_DAT,
    SEQ_H_CUR_CMD,
    SEQ_H_CUR_DAT,
    SEQ_V_START_CMD,
    SEQ_V_START_DAT,
    SEQ_V_END_CMD,
    SEQ_V_END_DAT,
    SEQ_V_CUR_CMD,
    SEQ_V_CUR_DAT,
    SEQ_FINAL
  } seq_state_t;

  function automatic logic [WORD_W-1:0] swap16(input logic [WORD_W-1:0] v);
    return {v[7:0], v[15:8]};
  endfunction

  function automatic axis_words_t make_axis(
    input logic [WORD_W-1:0] s,
    input logic [WORD_W-1:0] e,
    input logic              mirror,
    input logic [WORD_W-1:0] size,
    input logic [WORD_W-1:0] offset
  );
    logic [WORD_W-1:0] a;
    logic [WORD_W-1:0] b;
    logic [WORD_W-1:0] c;
    axis_words_t       w;
    if (mirror) begin
      a = size - e - 16'd1;
      b = size - s - 16'd1;
      c = b;
    end else begin
      a = s;
      b = e;
      c = s;
    end
    w.start_word  = swap16(a + offset);
    w.end_word    = swap16(b + offset);
    w.cursor_word = swap16(c + offset);
    return w;
  endfunction

endpackage

>>> src/dwcs_win_if.sv
// window channel: valid/ready handshake carrying one drawing window
// depends on nothing; coordinate width set by COORD_BITS
interface dwcs_win_if #(
  parameter int COORD_BITS = 10
);
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] x_start;
  logic [COORD_BITS-1:0] y_start;
  logic [COORD_BITS-1:0] x_end;
  logic [COORD_BITS-1:0] y_end;

  modport source (output valid, x_start, y_start, x_end, y_end, input ready);
  modport sink (input valid, x_start, y_start, x_end, y_end, output ready);
endinterface

>>> src/dwcs_word_if.sv
// bus word channel: valid/ready handshake carrying one command or data word
// depends on nothing
interface dwcs_word_if;
  logic        valid;
  logic        ready;
  logic        is_command;
  logic [15:0] bus_value;
  logic        last_word;

  modport source (output valid, is_command, bus_value, last_word, input ready);
  modport sink (input valid, is_command, bus_value, last_word, output ready);
endinterface

>>> src/dwcs_front.sv
// front end: accepts windows, applies axis swap and mirroring, checks the window cache
// depends on dwcs_pkg and dwcs_win_if
module dwcs_front #(
  parameter int COORD_BITS = 10
) (
  input  logic                  clk,
  input  logic                  rst,
  dwcs_win_if.sink              win,
  input  dwcs_pkg::geom_cfg_t   cfg,
  input  logic                  rot_write,
  input  logic                  q_full,
  output dwcs_pkg::push_t       push
);

  logic [COORD_BITS-1:0] cached_h_start;
  logic [COORD_BITS-1:0] cached_h_end;
  logic [COORD_BITS-1:0] cached_v_start;
  logic [COORD_BITS-1:0] cached_v_end;
  logic                  h_cache_valid;
  logic                  v_cache_valid;

  logic [COORD_BITS-1:0] hs, he, vs, ve;
  logic                  accept;
  logic                  send_h, send_v;
  logic                  mirror_h, mirror_v;

  assign win.ready = !q_full;
  assign accept    = win.valid && !q_full;

  always_comb begin
    if (cfg.rotation_code[0]) begin
      hs = win.y_start;
      he = win.y_end;
      vs = win.x_start;
      ve = win.x_end;
    end else begin
      hs = win.x_start;
      he = win.x_end;
      vs = win.y_start;
      ve = win.y_end;
    end
  end

  assign mirror_h = dwcs_pkg::MIRROR_H_SET[cfg.rotation_code];
  assign mirror_v = dwcs_pkg::MIRROR_V_SET[cfg.rotation_code];

  assign send_h = !h_cache_valid || (hs != cached_h_start) || (he != cached_h_end);
  assign send_v = !v_cache_valid || (vs != cached_v_start) || (ve != cached_v_end);

  always_comb begin
    push.valid        = accept;
    push.entry.send_h = send_h;
    push.entry.send_v = send_v;
    push.entry.h      = dwcs_pkg::make_axis(16'(hs), 16'(he), mirror_h,
                                            16'(cfg.h_size), 16'(cfg.column_offset));
    push.entry.v      = dwcs_pkg::make_axis(16'(vs), 16'(ve), mirror_v,
                                            16'(cfg.v_size), 16'(cfg.row_offset));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cached_h_start <= '0;
      cached_h_end   <= '0;
      cached_v_start <= '0;
      cached_v_end   <= '0;
      h_cache_valid  <= 1'b0;
      v_cache_valid  <= 1'b0;
    end else if (rot_write) begin
      h_cache_valid <= 1'b0;
      v_cache_valid <= 1'b0;
    end else if (accept) begin
      cached_h_start <= hs;
      cached_h_end   <= he;
      cached_v_start <= vs;
      cached_v_end   <= ve;
      h_cache_valid  <= 1'b1;
      v_cache_valid  <= 1'b1;
    end
  end

endmodule

>>> src/dwcs_queue.sv
// short queue of classified windows between front end and sequencer
// depends on dwcs_pkg
module dwcs_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  dwcs_pkg::push_t        push,
  input  logic                   pop,
  output logic                   full,
  output logic                   empty,
  output dwcs_pkg::win_entry_t   head
);

  dwcs_pkg::win_entry_t              slots [dwcs_pkg::QUEUE_DEPTH];
  logic [dwcs_pkg::QUEUE_PTR_W-1:0]  wr_ptr;
  logic [dwcs_pkg::QUEUE_PTR_W-1:0]  rd_ptr;
  logic [dwcs_pkg::QUEUE_CNT_W-1:0]  count;
  logic                              do_push, do_pop;

  localparam logic [dwcs_pkg::QUEUE_PTR_W-1:0] LAST_PTR =
    dwcs_pkg::QUEUE_PTR_W'(dwcs_pkg::QUEUE_DEPTH - 1);
  localparam logic [dwcs_pkg::QUEUE_CNT_W-1:0] DEPTH_CNT =
    dwcs_pkg::QUEUE_CNT_W'(dwcs_pkg::QUEUE_DEPTH);

  assign full    = (count == DEPTH_CNT);
  assign empty   = (count == '0);
  assign head    = slots[rd_ptr];
  assign do_push = push.valid && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push.entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> src/dwcs_back.sv
// sequencer: walks the head window through its command and data words
// depends on dwcs_pkg and dwcs_word_if
module dwcs_back (
  input  logic                   clk,
  input  logic                   rst,
  input  dwcs_pkg::win_entry_t   head,
  input  logic                   head_valid,
  input  logic [7:0]             final_command,
  output logic                   pop,
  dwcs_word_if.source            bus
);

  dwcs_pkg::seq_state_t state, state_next, cur;

  logic        advance;
  logic        word_cmd;
  logic [15:0] word_value;
  logic        word_last;

  logic        out_valid;
  logic        out_cmd;
  logic [15:0] out_value;
  logic        out_last;

  // state SEQ_NEXT means the head window has not started yet
  always_comb begin
    if (state == dwcs_pkg::SEQ_NEXT) begin
      if (head.send_h) begin
        cur = dwcs_pkg::SEQ_H_START_CMD;
      end else if (head.send_v) begin
        cur = dwcs_pkg::SEQ_V_START_CMD;
      end else begin
        cur = dwcs_pkg::SEQ_FINAL;
      end
    end else begin
      cur = state;
    end
  end

  assign advance = head_valid && (!out_valid || bus.ready);
  assign pop     = advance && (cur == dwcs_pkg::SEQ_FINAL);

  always_comb begin
    state_next = state;
    if (advance) begin
      unique case (cur)
        dwcs_pkg::SEQ_H_START_CMD: state_next = dwcs_pkg::SEQ_H_START_DAT;
        dwcs_pkg::SEQ_H_START_DAT: state_next = dwcs_pkg::SEQ_H_END_CMD;
        dwcs_pkg::SEQ_H_END_CMD:   state_next = dwcs_pkg::SEQ_H_END_DAT;
        dwcs_pkg::SEQ_H_END_DAT:   state_next = dwcs_pkg::SEQ_H_CUR_CMD;
        dwcs_pkg::SEQ_H_CUR_CMD:   state_next = dwcs_pkg::SEQ_H_CUR_DAT;
        dwcs_pkg::SEQ_H_CUR_DAT:   state_next = head.send_v ? dwcs_pkg::SEQ_V_START_CMD
                                                            : dwcs_pkg::SEQ_FINAL;
        dwcs_pkg::SEQ_V_START_CMD: state_next = dwcs_pkg::SEQ_V_START_DAT;
        dwcs_pkg::SEQ_V_START_DAT: state_next = dwcs_pkg::SEQ_V_END_CMD;
        dwcs_pkg::SEQ_V_END_CMD:   state_next = dwcs_pkg::SEQ_V_END_DAT;
        dwcs_pkg::SEQ_V_END_DAT:   state_next = dwcs_pkg::SEQ_V_CUR_CMD;
        dwcs_pkg::SEQ_V_CUR_CMD:   state_next = dwcs_pkg::SEQ_V_CUR_DAT;
        dwcs_pkg::SEQ_V_CUR_DAT:   state_next = dwcs_pkg::SEQ_FINAL;
        default:                   state_next = dwcs_pkg::SEQ_NEXT;
      endcase
    end
  end

  always_comb begin
    word_cmd   = 1'b1;
    word_value = 16'(final_command);
    word_last  = 1'b0;
    unique case (cur)
      dwcs_pkg::SEQ_H_START_CMD: word_value = 16'(dwcs_pkg::CMD_H_START);
      dwcs_pkg::SEQ_H_END_CMD:   word_value = 16'(dwcs_pkg::CMD_H_END);
      dwcs_pkg::SEQ_H_CUR_CMD:   word_value = 16'(dwcs_pkg::CMD_H_CURSOR);
      dwcs_pkg::SEQ_V_START_CMD: word_value = 16'(dwcs_pkg::CMD_V_START);
      dwcs_pkg::SEQ_V_END_CMD:   word_value = 16'(dwcs_pkg::CMD_V_END);
      dwcs_pkg::SEQ_V_CUR_CMD:   word_value = 16'(dwcs_pkg::CMD_V_CURSOR);
      dwcs_pkg::SEQ_H_START_DAT: begin
        word_cmd   = 1'b0;
        word_value = head.h.start_word;
      end
      dwcs_pkg::SEQ_H_END_DAT: begin
        word_cmd   = 1'b0;
        word_value = head.h.end_word;
      end
      dwcs_pkg::SEQ_H_CUR_DAT: begin
        word_cmd   = 1'b0;
        word_value = head.h.cursor_word;
      end
      dwcs_pkg::SEQ_V_START_DAT: begin
        word_cmd   = 1'b0;
        word_value = head.v.start_word;
      end
      dwcs_pkg::SEQ_V_END_DAT: begin
        word_cmd   = 1'b0;
        word_value = head.v.end_word;
      end
      dwcs_pkg::SEQ_V_CUR_DAT: begin
        word_cmd   = 1'b0;
        word_value = head.v.cursor_word;
      end
      default: word_last = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= dwcs_pkg::SEQ_NEXT;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (advance) begin
        out_valid <= 1'b1;
      end else if (bus.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_cmd   <= word_cmd;
      out_value <= word_value;
      out_last  <= word_last;
    end
  end

  assign bus.valid      = out_valid;
  assign bus.is_command = out_cmd;
  assign bus.bus_value  = out_value;
  assign bus.last_word  = out_last;

endmodule

>>> src/display_window_command_sequencer.sv
// Sends one command or data word per cycle on the bus channel while the receiver is
// ready. A window takes 13 words when both axes change, 7 when one does and 1 when
// neither does, through the single word-wide output register. The front end classifies
// a window and hands it on through a two-entry queue, so windows are taken while
// earlier ones are being sent, and the sequencer runs from one window into the next
// with no gap. A rotation write drops the cached windows so both axes go out again.
// depends on dwcs_pkg, dwcs_win_if, dwcs_word_if, dwcs_front, dwcs_queue, dwcs_back
module display_window_command_sequencer #(
  parameter int COORD_BITS = 10
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_write,
  input  logic [dwcs_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [dwcs_pkg::CFG_DATA_W-1:0]       cfg_data,
  dwcs_win_if.sink                              win,
  dwcs_word_if.source                           bus
);

  dwcs_pkg::geom_cfg_t  geom;
  logic [7:0]           final_command;
  logic                 rot_write;

  dwcs_pkg::push_t      push;
  dwcs_pkg::win_entry_t head;
  logic                 q_full, q_empty, q_pop;

  assign rot_write = cfg_write && (cfg_index == dwcs_pkg::REG_ROTATION);

  always_ff @(posedge clk) begin
    if (rst) begin
      geom.rotation_code <= dwcs_pkg::ROTATION_RESET;
      geom.h_size        <= dwcs_pkg::H_SIZE_RESET;
      geom.v_size        <= dwcs_pkg::V_SIZE_RESET;
      geom.column_offset <= dwcs_pkg::OFFSET_RESET;
      geom.row_offset    <= dwcs_pkg::OFFSET_RESET;
      final_command      <= dwcs_pkg::FINAL_COMMAND_RESET;
    end else if (cfg_write) begin
      unique case (dwcs_pkg::cfg_reg_t'(cfg_index))
        dwcs_pkg::REG_ROTATION:      geom.rotation_code <= cfg_data[dwcs_pkg::ROT_W-1:0];
        dwcs_pkg::REG_H_SIZE:        geom.h_size        <= cfg_data;
        dwcs_pkg::REG_V_SIZE:        geom.v_size        <= cfg_data;
        dwcs_pkg::REG_COLUMN_OFFSET: geom.column_offset <= cfg_data[dwcs_pkg::OFFSET_W-1:0];
        dwcs_pkg::REG_ROW_OFFSET:    geom.row_offset    <= cfg_data[dwcs_pkg::OFFSET_W-1:0];
        dwcs_pkg::REG_FINAL_COMMAND: final_command      <= cfg_data[dwcs_pkg::CMD_W-1:0];
        default: ;
      endcase
    end
  end

  dwcs_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .win       (win),
    .cfg       (geom),
    .rot_write (rot_write),
    .q_full    (q_full),
    .push      (push)
  );

  dwcs_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .pop   (q_pop),
    .full  (q_full),
    .empty (q_empty),
    .head  (head)
  );

  dwcs_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head          (head),
    .head_valid    (!q_empty),
    .final_command (final_command),
    .pop           (q_pop),
    .bus           (bus)
  );

  // front end never pushes into a full queue
  assert property (@(posedge clk) disable iff (rst) push.valid |-> !q_full)
    else $error("window pushed into full queue");

  // the sequencer only retires a window that is present
  assert property (@(posedge clk) disable iff (rst) q_pop |-> !q_empty)
    else $error("pop from empty queue");

  // a retired window leaves its closing command in the output register
  assert property (@(posedge clk) disable iff (rst)
    q_pop |=> (bus.valid && bus.last_word && bus.is_command))
    else $error("window retired without closing command");

endmodule

>>> tb/sv/display_window_command_sequencer_tb.sv
`timescale 1ns / 100ps
// testbench for the display window command sequencer: directed and random windows and register settings
// depends on dwcs_pkg, dwcs_win_if, dwcs_word_if and the sequencer itself
module display_window_command_sequencer_tb;

  localparam int COORD_BITS = 10;
  localparam int RANDOM_WINDOWS = 500;
  localparam logic [COORD_BITS-1:0] COORD_MAX = {COORD_BITS{1'b1}};

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [dwcs_pkg::CFG_DATA_W-1:0] cfg_word_t;
  typedef logic [dwcs_pkg::WORD_W-1:0] bus_val_t;

  typedef struct packed {
    coord_t xs;
    coord_t ys;
    coord_t xe;
    coord_t ye;
    bit     drain_first;
  } window_item_t;

  typedef struct packed {
    logic     is_command;
    bus_val_t bus_value;
    logic     last_word;
  } bus_word_t;

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SLOW, RX_PERIODIC} rx_mode_t;

  logic                             clk;
  logic                             rst;
  logic                             cfg_write;
  logic [dwcs_pkg::CFG_INDEX_W-1:0] cfg_index;
  cfg_word_t                        cfg_data;

  dwcs_win_if #(.COORD_BITS(COORD_BITS)) win_ch ();
  dwcs_word_if bus_ch ();

  display_window_command_sequencer #(.COORD_BITS(COORD_BITS)) i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .win       (win_ch),
    .bus       (bus_ch)
  );

  // predictor copy of the registers and the window cache
  logic [dwcs_pkg::ROT_W-1:0]    rot_setting;
  logic [dwcs_pkg::SIZE_W-1:0]   width_setting;
  logic [dwcs_pkg::SIZE_W-1:0]   height_setting;
  logic [dwcs_pkg::OFFSET_W-1:0] col_shift;
  logic [dwcs_pkg::OFFSET_W-1:0] row_shift;
  logic [dwcs_pkg::CMD_W-1:0]    close_cmd;
  coord_t                        h_last_lo, h_last_hi, v_last_lo, v_last_hi;
  logic                          h_seen, v_seen;

  window_item_t staged_windows[$];
  window_item_t window_queue[$];
  bus_word_t    awaited_words[$];
  window_item_t cur_window;
  window_item_t prev_window;

  int unsigned n_queued;
  int unsigned n_accepted;
  int unsigned n_predicted;
  int unsigned n_checked;
  int unsigned n_failures;
  int unsigned n_settings;
  int unsigned n_h_sends;
  int unsigned n_v_sends;
  int unsigned n_full_hits;
  int unsigned burst_left;
  int unsigned gap_left;
  int unsigned stall_left;
  int unsigned stall_period;
  int unsigned stall_tick;
  rx_mode_t    stall_mode;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #1_000_000;
    $display("[display_window_command_sequencer] ERROR");
    $finish;
  end

  function automatic void note_failure(input string msg);
    n_failures++;
    if (n_failures <= 10) $display("%s", msg);
  endfunction

  function automatic void push_word(input logic is_cmd, input bus_val_t v,
                                    input logic last);
    bus_word_t w;
    w.is_command = is_cmd;
    w.bus_value  = v;
    w.last_word  = last;
    awaited_words.push_back(w);
  endfunction

  // address plus offset, wrapped to 16 bits, high and low bytes exchanged
  function automatic bus_val_t addr_word(input bus_val_t base,
                                         input logic [dwcs_pkg::OFFSET_W-1:0] shift);
    bus_val_t t;
    t = base + dwcs_pkg::WORD_W'(shift);
    return {t[7:0], t[15:8]};
  endfunction

  function automatic void emit_axis(input coord_t lo_in, input coord_t hi_in,
                                    input logic mirror,
                                    input logic [dwcs_pkg::SIZE_W-1:0] span,
                                    input logic [dwcs_pkg::OFFSET_W-1:0] shift,
                                    input logic [dwcs_pkg::CMD_W-1:0] c_lo,
                                    input logic [dwcs_pkg::CMD_W-1:0] c_hi,
                                    input logic [dwcs_pkg::CMD_W-1:0] c_cur);
    bus_val_t span16, lo, hi, cur;
    span16 = dwcs_pkg::WORD_W'(span);
    if (mirror) begin
      lo  = span16 - dwcs_pkg::WORD_W'(hi_in) - 16'd1;
      hi  = span16 - dwcs_pkg::WORD_W'(lo_in) - 16'd1;
      cur = hi;
    end else begin
      lo  = dwcs_pkg::WORD_W'(lo_in);
      hi  = dwcs_pkg::WORD_W'(hi_in);
      cur = dwcs_pkg::WORD_W'(lo_in);
    end
    push_word(1'b1, {8'h00, c_lo}, 1'b0);
    push_word(1'b0, addr_word(lo, shift), 1'b0);
    push_word(1'b1, {8'h00, c_hi}, 1'b0);
    push_word(1'b0, addr_word(hi, shift), 1'b0);
    push_word(1'b1, {8'h00, c_cur}, 1'b0);
    push_word(1'b0, addr_word(cur, shift), 1'b0);
  endfunction

  // queue the words one accepted window must produce; returns their number
  function automatic int unsigned expand_window(input window_item_t w);
    coord_t      hs, he, vs, ve;
    int unsigned n;
    n = 1;
    if (rot_setting[0]) begin
      hs = w.ys; he = w.ye; vs = w.xs; ve = w.xe;
    end else begin
      hs = w.xs; he = w.xe; vs = w.ys; ve = w.ye;
    end
    if (!h_seen || hs != h_last_lo || he != h_last_hi) begin
      h_last_lo = hs;
      h_last_hi = he;
      h_seen    = 1'b1;
      emit_axis(hs, he, dwcs_pkg::MIRROR_H_SET[rot_setting], width_setting, col_shift,
                dwcs_pkg::CMD_H_START, dwcs_pkg::CMD_H_END, dwcs_pkg::CMD_H_CURSOR);
      n += 6;
      n_h_sends++;
    end
    if (!v_seen || vs != v_last_lo || ve != v_last_hi) begin
      v_last_lo = vs;
      v_last_hi = ve;
      v_seen    = 1'b1;
      emit_axis(vs, ve, dwcs_pkg::MIRROR_V_SET[rot_setting], height_setting, row_shift,
                dwcs_pkg::CMD_V_START, dwcs_pkg::CMD_V_END, dwcs_pkg::CMD_V_CURSOR);
      n += 6;
      n_v_sends++;
    end
    if (n == 1) n_full_hits++;
    push_word(1'b1, {8'h00, close_cmd}, 1'b1);
    return n;
  endfunction

  // window driver
  always @(posedge clk) begin
    logic        fire;
    int unsigned words;
    if (rst) begin
      win_ch.valid <= 1'b0;
    end else begin
      fire = win_ch.valid && win_ch.ready;
      if (fire) begin
        words = expand_window(cur_window);
        n_predicted <= n_predicted + words;
        n_accepted  <= n_accepted + 1;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
        end
      end
      if (win_ch.valid && !fire) begin
        // offer stays up until taken
      end else if (gap_left > 0) begin
        gap_left--;
        win_ch.valid <= 1'b0;
      end else if (window_queue.size() > 0 && (!window_queue[0].drain_first ||
                   (!fire && n_predicted == n_checked))) begin
        cur_window = window_queue.pop_front();
        win_ch.valid   <= 1'b1;
        win_ch.x_start <= cur_window.xs;
        win_ch.y_start <= cur_window.ys;
        win_ch.x_end   <= cur_window.xe;
        win_ch.y_end   <= cur_window.ye;
      end else begin
        win_ch.valid <= 1'b0;
      end
    end
  end

  // bus word monitor and receiver stalls
  always @(posedge clk) begin
    bus_word_t got;
    bus_word_t want;
    logic      nxt;
    if (rst) begin
      bus_ch.ready <= 1'b0;
    end else begin
      if (bus_ch.valid && bus_ch.ready) begin
        got.is_command = bus_ch.is_command;
        got.bus_value  = bus_ch.bus_value;
        got.last_word  = bus_ch.last_word;
        if (awaited_words.size() == 0) begin
          note_failure($sformatf("unexpected bus word cmd=%0b value=%04h last=%0b",
                                 got.is_command, got.bus_value, got.last_word));
        end else begin
          want = awaited_words.pop_front();
          n_checked <= n_checked + 1;
          if (got.is_command !== want.is_command || got.bus_value !== want.bus_value ||
              got.last_word !== want.last_word)
            note_failure($sformatf(
              "bus word %0d: expected cmd=%0b value=%04h last=%0b, got cmd=%0b value=%04h last=%0b",
              n_checked, want.is_command, want.bus_value, want.last_word,
              got.is_command, got.bus_value, got.last_word));
        end
      end
      if (stall_left == 0) begin
        stall_mode   = rx_mode_t'($urandom_range(0, 3));
        stall_left   = $urandom_range(16, 160);
        stall_period = $urandom_range(2, 13);
      end
      stall_left--;
      stall_tick++;
      case (stall_mode)
        RX_OPEN: nxt = 1'b1;
        RX_COIN: nxt = 1'($urandom_range(0, 1));
        RX_SLOW: nxt = ($urandom_range(0, 7) == 0);
        default: nxt = (stall_tick % stall_period) != 0;
      endcase
      bus_ch.ready <= nxt;
    end
  end

  task automatic write_one(input dwcs_pkg::cfg_reg_t r, input cfg_word_t v);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= r;
    cfg_data  <= v;
    case (r)
      dwcs_pkg::REG_ROTATION: begin
        rot_setting = v[dwcs_pkg::ROT_W-1:0];
        h_seen      = 1'b0;
        v_seen      = 1'b0;
      end
      dwcs_pkg::REG_H_SIZE:        width_setting  = v[dwcs_pkg::SIZE_W-1:0];
      dwcs_pkg::REG_V_SIZE:        height_setting = v[dwcs_pkg::SIZE_W-1:0];
      dwcs_pkg::REG_COLUMN_OFFSET: col_shift      = v[dwcs_pkg::OFFSET_W-1:0];
      dwcs_pkg::REG_ROW_OFFSET:    row_shift      = v[dwcs_pkg::OFFSET_W-1:0];
      dwcs_pkg::REG_FINAL_COMMAND: close_cmd      = v[dwcs_pkg::CMD_W-1:0];
      default: ;
    endcase
  endtask

  task automatic finish_writes();
    @(posedge clk);
    cfg_write <= 1'b0;
    n_settings++;
  endtask

  task automatic stage(input coord_t xs, input coord_t ys, input coord_t xe, input coord_t ye,
                       input bit drain);
    window_item_t w;
    w.xs = xs; w.ys = ys; w.xe = xe; w.ye = ye;
    w.drain_first = drain;
    staged_windows.push_back(w);
    prev_window = w;
  endtask

  task automatic wait_quiet();
    do @(posedge clk); while (n_accepted != n_queued || n_checked != n_predicted);
    repeat (3) @(posedge clk);
  endtask

  task automatic run_phase();
    @(negedge clk);
    while (staged_windows.size() > 0) begin
      window_queue.push_back(staged_windows.pop_front());
      n_queued++;
    end
    wait_quiet();
  endtask

  function automatic coord_t rand_coord();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return COORD_MAX;
      2:       return coord_t'($urandom_range(0, 15));
      default: return coord_t'($urandom_range(0, COORD_MAX));
    endcase
  endfunction

  function automatic cfg_word_t rand_size();
    case ($urandom_range(0, 7))
      0:       return 11'd1;
      1:       return 11'd1024;
      2:       return 11'd0;
      3:       return 11'h7ff;
      default: return cfg_word_t'($urandom_range(1, 1024));
    endcase
  endfunction

  function automatic cfg_word_t rand_offset();
    case ($urandom_range(0, 5))
      0:       return 11'd0;
      1:       return 11'd1023;
      2:       return cfg_word_t'($urandom_range(0, 2047));  // upper bit ignored
      default: return cfg_word_t'($urandom_range(0, 1023));
    endcase
  endfunction

  task automatic random_setting();
    logic [5:0] mask;
    mask = 6'($urandom_range(1, 63));
    if (mask[dwcs_pkg::REG_ROTATION])
      write_one(dwcs_pkg::REG_ROTATION,
                cfg_word_t'($urandom_range(0, 1) ? $urandom_range(0, 7)
                                                 : $urandom_range(0, 2047)));
    if (mask[dwcs_pkg::REG_H_SIZE]) write_one(dwcs_pkg::REG_H_SIZE, rand_size());
    if (mask[dwcs_pkg::REG_V_SIZE]) write_one(dwcs_pkg::REG_V_SIZE, rand_size());
    if (mask[dwcs_pkg::REG_COLUMN_OFFSET])
      write_one(dwcs_pkg::REG_COLUMN_OFFSET, rand_offset());
    if (mask[dwcs_pkg::REG_ROW_OFFSET])
      write_one(dwcs_pkg::REG_ROW_OFFSET, rand_offset());
    if (mask[dwcs_pkg::REG_FINAL_COMMAND])
      write_one(dwcs_pkg::REG_FINAL_COMMAND,
                cfg_word_t'($urandom_range(0, 3) == 0 ? $urandom_range(0, 2047)
                                                      : $urandom_range(0, 255)));
    finish_writes();
  endtask

  // mostly repeats and single-axis changes so the window cache gets exercised
  task automatic stage_random();
    window_item_t w;
    bit           drain;
    w = prev_window;
    drain = ($urandom_range(0, 39) == 0);
    case ($urandom_range(0, 9))
      0, 1, 2, 3: begin
        w.xs = rand_coord(); w.xe = rand_coord();
        w.ys = rand_coord(); w.ye = rand_coord();
      end
      4, 5: ;
      6, 7: begin
        w.xs = rand_coord(); w.xe = rand_coord();
      end
      default: begin
        w.ys = rand_coord(); w.ye = rand_coord();
      end
    endcase
    stage(w.xs, w.ys, w.xe, w.ye, drain);
  endtask

  initial begin
    int unsigned n_random;
    int unsigned count;
    clk = 1'b0;
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = dwcs_pkg::REG_ROTATION;
    cfg_data  = '0;
    win_ch.valid = 1'b0;
    win_ch.x_start = '0;
    win_ch.y_start = '0;
    win_ch.x_end   = '0;
    win_ch.y_end   = '0;
    bus_ch.ready   = 1'b0;
    rot_setting    = dwcs_pkg::ROTATION_RESET;
    width_setting  = dwcs_pkg::H_SIZE_RESET;
    height_setting = dwcs_pkg::V_SIZE_RESET;
    col_shift      = dwcs_pkg::OFFSET_RESET;
    row_shift      = dwcs_pkg::OFFSET_RESET;
    close_cmd      = dwcs_pkg::FINAL_COMMAND_RESET;
    h_last_lo = '0; h_last_hi = '0; v_last_lo = '0; v_last_hi = '0;
    h_seen = 1'b0;
    v_seen = 1'b0;
    n_queued = 0; n_accepted = 0; n_predicted = 0; n_checked = 0;
    n_failures = 0; n_settings = 0; n_h_sends = 0; n_v_sends = 0; n_full_hits = 0;
    burst_left = 1; gap_left = 0;
    stall_left = 0; stall_period = 2; stall_tick = 0; stall_mode = RX_OPEN;
    n_random = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // reset settings: all-zero window must go out although it equals the cleared cache
    stage('0, '0, '0, '0, 1'b0);
    stage('0, '0, '0, '0, 1'b0);
    stage(10'd5, '0, 10'd9, '0, 1'b0);
    stage(10'd5, 10'd7, 10'd9, 10'd3, 1'b0);
    stage(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 1'b0);
    stage('0, COORD_MAX, COORD_MAX, '0, 1'b1);
    run_phase();

    // both axes mirrored, zero width wraps the addresses and the height is oversized
    write_one(dwcs_pkg::REG_ROTATION, 11'd7);
    write_one(dwcs_pkg::REG_H_SIZE, 11'd0);
    write_one(dwcs_pkg::REG_V_SIZE, 11'h7ff);
    write_one(dwcs_pkg::REG_COLUMN_OFFSET, 11'd1023);
    write_one(dwcs_pkg::REG_ROW_OFFSET, 11'd1023);
    write_one(dwcs_pkg::REG_FINAL_COMMAND, 11'd255);
    finish_writes();
    stage('0, '0, '0, '0, 1'b0);
    stage(COORD_MAX, '0, COORD_MAX, COORD_MAX, 1'b0);
    stage(COORD_MAX, '0, COORD_MAX, COORD_MAX, 1'b0);
    run_phase();

    // offset writes keep the cache, so the same window sends only the close
    write_one(dwcs_pkg::REG_COLUMN_OFFSET, 11'd0);
    write_one(dwcs_pkg::REG_ROW_OFFSET, 11'd512);
    finish_writes();
    stage(COORD_MAX, '0, COORD_MAX, COORD_MAX, 1'b0);
    stage(10'd3, COORD_MAX, 10'd5, COORD_MAX, 1'b0);
    run_phase();

    // rewriting the same rotation still drops the cache
    write_one(dwcs_pkg::REG_ROTATION, 11'd7);
    finish_writes();
    stage(10'd3, COORD_MAX, 10'd5, COORD_MAX, 1'b0);
    run_phase();

    write_one(dwcs_pkg::REG_H_SIZE, 11'd1024);
    write_one(dwcs_pkg::REG_V_SIZE, 11'd1);
    write_one(dwcs_pkg::REG_COLUMN_OFFSET, 11'd1);
    write_one(dwcs_pkg::REG_FINAL_COMMAND, 11'd0);
    finish_writes();
    for (int r = 1; r <= 6; r++) begin
      write_one(dwcs_pkg::REG_ROTATION, cfg_word_t'(r));
      finish_writes();
      stage(10'd17, 10'd200, 10'd900, 10'd2, 1'b0);
      run_phase();
    end

    while (n_random < RANDOM_WINDOWS) begin
      random_setting();
      count = $urandom_range(30, 70);
      repeat (count) stage_random();
      n_random += count;
      run_phase();
    end

    repeat (16) @(posedge clk);
    if (awaited_words.size() != 0)
      note_failure($sformatf("%0d bus words never arrived", awaited_words.size()));
    $display("windows accepted: %0d under %0d register settings, bus words checked: %0d",
             n_accepted, n_settings, n_checked);
    $display("horizontal sends: %0d, vertical sends: %0d, windows fully cached: %0d",
             n_h_sends, n_v_sends, n_full_hits);
    if (n_failures == 0) begin
      $display("[display_window_command_sequencer] OK");
    end else begin
      $display("[display_window_command_sequencer] ERROR");
    end
    $finish;
  end

endmodule

>>> sim.f
src/dwcs_pkg.sv
src/dwcs_win_if.sv
src/dwcs_word_if.sv
src/dwcs_front.sv
src/dwcs_queue.sv
src/dwcs_back.sv
src/display_window_command_sequencer.sv
tb/sv/display_window_command_sequencer_tb.sv
